// ----- sv/msri_pkg.sv -----
`timescale 1ns / 1ps
package msri_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;
  localparam int FX_W        = 64;

  typedef logic signed [FX_W-1:0] fx_t;
  typedef logic signed [31:0]     w32_t;

  localparam fx_t LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [FX_W:0] LIM65 = 65'sh0_3FFF_FFFF_FFFF_FFFF;

  // output clamp bounds
  localparam fx_t OUT_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
  localparam fx_t OUT_LO = -OUT_HI - 64'sd1;

  // unit latencies
  localparam int DIV_ITERS  = 63 + FRAC_BITS;
  localparam int DIV_LAT    = DIV_ITERS + 1;
  localparam int SQRT_ITERS = (63 + FRAC_BITS) / 2;
  localparam int SQRT_LAT   = SQRT_ITERS + 1;
  localparam int MUL_LAT    = 3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int ADDR_W    = 6;
  localparam int REG_IDX_W = 3;

  typedef struct packed {
    w32_t [2:0] cs;
    w32_t [2:0] ce;
    w32_t       s0;
    w32_t       s1;
    w32_t       r;
  } cfg_t;

  typedef struct packed {
    w32_t [2:0] o;
    w32_t [2:0] d;
    w32_t       tm;
    w32_t       tlo;
    w32_t       thi;
  } ray_t;

  typedef struct packed {
    ray_t      ray;
    fx_t [2:0] c;
    fx_t       a;
    fx_t       b;
    fx_t       disc;
    logic      miss;
  } qent_t;

  typedef struct packed {
    logic       hit;
    w32_t       t;
    w32_t [2:0] p;
    w32_t [2:0] n;
  } res_t;

  function automatic fx_t sx32(input w32_t v);
    return fx_t'(v);
  endfunction

  function automatic fx_t sat65(input logic signed [FX_W:0] v);
    fx_t r;
    if (v > LIM65) r = LIM;
    else if (v < -LIM65) r = -LIM;
    else r = v[FX_W-1:0];
    return r;
  endfunction

  function automatic fx_t sadd(input fx_t x, input fx_t y);
    logic signed [FX_W:0] s;
    s = (FX_W+1)'(x) + (FX_W+1)'(y);
    return sat65(s);
  endfunction

  function automatic fx_t ssub(input fx_t x, input fx_t y);
    logic signed [FX_W:0] s;
    s = (FX_W+1)'(x) - (FX_W+1)'(y);
    return sat65(s);
  endfunction

  function automatic logic [FX_W-1:0] mag(input fx_t v);
    return v[FX_W-1] ? FX_W'(-v) : FX_W'(v);
  endfunction

  function automatic w32_t outw(input fx_t v);
    fx_t c;
    if (v > OUT_HI) c = OUT_HI;
    else if (v < OUT_LO) c = OUT_LO;
    else c = v;
    return c[31:0];
  endfunction

endpackage

// ----- sv/moving_sphere_ray_intersect_core.sv -----
`timescale 1ns / 1ps
// channel   dir  handshake           payload
// cfg       in   psel/penable/pready paddr, pwdata (64b), prdata; reg i at 8*i
// in        in   in_valid/in_ready   origin, dir, ray_time, t_min, t_max
// out       out  out_valid/out_ready hit, hit_t, point, normal
//
// One word accepted per cycle while the queue has room. The path holds three
// 80-stage restoring dividers (center fraction, t, normal) and the 40-stage
// square root. Synchronous active-low reset clears valids, queue pointers and
// config registers; no memory clearing pass. Output stalls freeze the back
// pipe; the 4-word queue lets the front run on until full.
module moving_sphere_ray_intersect_core import msri_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  // ray in
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       in_origin_x,
  input  logic [31:0]       in_origin_y,
  input  logic [31:0]       in_origin_z,
  input  logic [31:0]       in_dir_x,
  input  logic [31:0]       in_dir_y,
  input  logic [31:0]       in_dir_z,
  input  logic [31:0]       in_ray_time,
  input  logic [31:0]       in_t_min,
  input  logic [31:0]       in_t_max,
  // result out
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_hit,
  output logic [31:0]       out_hit_t,
  output logic [31:0]       out_point_x,
  output logic [31:0]       out_point_y,
  output logic [31:0]       out_point_z,
  output logic [31:0]       out_normal_x,
  output logic [31:0]       out_normal_y,
  output logic [31:0]       out_normal_z
);

  localparam logic [REG_IDX_W-1:0] REG_CS_X    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CS_Y    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CS_Z    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CE_X    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CE_Y    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CE_Z    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SHUTTER = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_RADIUS  = 3'd7;

  cfg_t cfg_r, cfg_nxt;
  logic [REG_IDX_W-1:0] idx;
  logic wr;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:3];
  assign wr     = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_CS_X:    cfg_nxt.cs[0] = pwdata[31:0];
        REG_CS_Y:    cfg_nxt.cs[1] = pwdata[31:0];
        REG_CS_Z:    cfg_nxt.cs[2] = pwdata[31:0];
        REG_CE_X:    cfg_nxt.ce[0] = pwdata[31:0];
        REG_CE_Y:    cfg_nxt.ce[1] = pwdata[31:0];
        REG_CE_Z:    cfg_nxt.ce[2] = pwdata[31:0];
        REG_SHUTTER: begin
          cfg_nxt.s0 = pwdata[31:0];
          cfg_nxt.s1 = pwdata[63:32];
        end
        REG_RADIUS:  cfg_nxt.r = pwdata[31:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CS_X:    prdata = {32'b0, cfg_r.cs[0]};
      REG_CS_Y:    prdata = {32'b0, cfg_r.cs[1]};
      REG_CS_Z:    prdata = {32'b0, cfg_r.cs[2]};
      REG_CE_X:    prdata = {32'b0, cfg_r.ce[0]};
      REG_CE_Y:    prdata = {32'b0, cfg_r.ce[1]};
      REG_CE_Z:    prdata = {32'b0, cfg_r.ce[2]};
      REG_SHUTTER: prdata = {cfg_r.s1, cfg_r.s0};
      REG_RADIUS:  prdata = {32'b0, cfg_r.r};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= '0;
    else cfg_r <= cfg_nxt;
  end

  ray_t  in_ray;
  qent_t q_wdata, q_rdata;
  logic  q_push, q_pop, q_full, q_empty;
  res_t  res;

  always_comb begin
    in_ray.o[0] = in_origin_x;
    in_ray.o[1] = in_origin_y;
    in_ray.o[2] = in_origin_z;
    in_ray.d[0] = in_dir_x;
    in_ray.d[1] = in_dir_y;
    in_ray.d[2] = in_dir_z;
    in_ray.tm   = in_ray_time;
    in_ray.tlo  = in_t_min;
    in_ray.thi  = in_t_max;
  end

  msri_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_valid), .in_ready(in_ready), .in_ray(in_ray),
    .q_full(q_full), .q_push(q_push), .q_wdata(q_wdata)
  );

  msri_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wdata(q_wdata),
    .pop(q_pop), .rdata(q_rdata), .full(q_full), .empty(q_empty)
  );

  msri_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .q_empty(q_empty), .q_rdata(q_rdata), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_res(res)
  );

  assign out_hit      = res.hit;
  assign out_hit_t    = res.t;
  assign out_point_x  = res.p[0];
  assign out_point_y  = res.p[1];
  assign out_point_z  = res.p[2];
  assign out_normal_x = res.n[0];
  assign out_normal_y = res.n[1];
  assign out_normal_z = res.n[2];

endmodule

// ----- sv/msri_mul.sv -----
`timescale 1ns / 1ps
// Q-format multiply, (x*y)>>FRAC_BITS toward zero, saturated. 3 stages.
module msri_mul import msri_pkg::*; (
  input  logic clk,
  input  logic en,
  input  fx_t  x,
  input  fx_t  y,
  output fx_t  p
);

  logic [63:0] ux_r, uy_r;
  logic        neg_r, neg2_r;
  logic [63:0] p00_r, p01_r, p10_r, p11_r;
  fx_t         p_r;

  logic [63:0] mid, lo, hi, q;
  fx_t         p_nxt;

  always_comb begin
    mid = {32'b0, p00_r[63:32]} + {32'b0, p01_r[31:0]} + {32'b0, p10_r[31:0]};
    lo  = {mid[31:0], p00_r[31:0]};
    hi  = p11_r + {32'b0, p01_r[63:32]} + {32'b0, p10_r[63:32]} + {32'b0, mid[63:32]};
    if (hi[63:FRAC_BITS] != '0) q = 64'(LIM);
    else q = {hi[FRAC_BITS-1:0], lo[63:FRAC_BITS]};
    if (q > 64'(LIM)) q = 64'(LIM);
    p_nxt = neg2_r ? -$signed(q) : $signed(q);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r   <= mag(x);
      uy_r   <= mag(y);
      neg_r  <= x[FX_W-1] ^ y[FX_W-1];
      p00_r  <= ux_r[31:0] * uy_r[31:0];
      p01_r  <= ux_r[31:0] * uy_r[63:32];
      p10_r  <= ux_r[63:32] * uy_r[31:0];
      p11_r  <= ux_r[63:32] * uy_r[63:32];
      neg2_r <= neg_r;
      p_r    <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

// ----- sv/msri_div.sv -----
`timescale 1ns / 1ps
// (n<<FRAC_BITS)/d toward zero, saturated; one restoring step per stage.
module msri_div import msri_pkg::*; (
  input  logic clk,
  input  logic en,
  input  fx_t  n,
  input  fx_t  d,
  output fx_t  q
);

  logic [63:0] un_r  [DIV_LAT];
  logic [63:0] ud_r  [DIV_LAT];
  logic [63:0] rem_r [DIV_LAT];
  logic [63:0] quo_r [DIV_LAT];
  logic        sat_r [DIV_LAT];
  logic        neg_r [DIV_LAT];
  logic        dz_r  [DIV_LAT];

  logic [DIV_ITERS-1:0] nbits;
  logic [63:0] rs_c  [DIV_ITERS];
  logic [63:0] rn_c  [DIV_ITERS];
  logic [63:0] qn_c  [DIV_ITERS];

  genvar k;
  for (k = 0; k < DIV_ITERS; k++) begin : g_bit
    localparam int BitPos = DIV_ITERS - 1 - k - FRAC_BITS;
    if (BitPos >= 0) begin : g_num
      assign nbits[k] = un_r[k][BitPos];
    end else begin : g_pad
      assign nbits[k] = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < DIV_ITERS; i++) begin
      rs_c[i] = {rem_r[i][62:0], nbits[i]};
      if (rs_c[i] >= ud_r[i]) begin
        rn_c[i] = rs_c[i] - ud_r[i];
        qn_c[i] = {quo_r[i][62:0], 1'b1};
      end else begin
        rn_c[i] = rs_c[i];
        qn_c[i] = {quo_r[i][62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      un_r[0]  <= mag(n);
      ud_r[0]  <= mag(d);
      rem_r[0] <= '0;
      quo_r[0] <= '0;
      sat_r[0] <= 1'b0;
      neg_r[0] <= n[FX_W-1] ^ d[FX_W-1];
      dz_r[0]  <= (d == '0);
      for (int i = 0; i < DIV_ITERS; i++) begin
        un_r[i+1]  <= un_r[i];
        ud_r[i+1]  <= ud_r[i];
        rem_r[i+1] <= rn_c[i];
        quo_r[i+1] <= qn_c[i];
        // sticky: once past the limit the result is the limit
        sat_r[i+1] <= sat_r[i] | (qn_c[i] > 64'(LIM));
        neg_r[i+1] <= neg_r[i];
        dz_r[i+1]  <= dz_r[i];
      end
    end
  end

  logic [63:0] qm;
  assign qm = sat_r[DIV_LAT-1] ? 64'(LIM) : quo_r[DIV_LAT-1];
  assign q  = dz_r[DIV_LAT-1] ? '0 :
              (neg_r[DIV_LAT-1] ? -$signed(qm) : $signed(qm));

endmodule

// ----- sv/msri_sqrt.sv -----
`timescale 1ns / 1ps
// floor(sqrt(v<<FRAC_BITS)); one bit pair per stage.
module msri_sqrt import msri_pkg::*; (
  input  logic clk,
  input  logic en,
  input  fx_t  v,
  output fx_t  s
);

  logic [63:0] u_r    [SQRT_LAT];
  logic [63:0] rem_r  [SQRT_LAT];
  logic [63:0] root_r [SQRT_LAT];

  logic [SQRT_ITERS-1:0] hb, lb;
  logic [63:0] rs_c [SQRT_ITERS];
  logic [63:0] tr_c [SQRT_ITERS];
  logic [63:0] rn_c [SQRT_ITERS];
  logic [63:0] qn_c [SQRT_ITERS];

  genvar j;
  for (j = 0; j < SQRT_ITERS; j++) begin : g_bit
    localparam int HiPos = 2 * (SQRT_ITERS - 1 - j) + 1 - FRAC_BITS;
    localparam int LoPos = HiPos - 1;
    if (HiPos >= 0) begin : g_hi
      assign hb[j] = u_r[j][HiPos];
    end else begin : g_hz
      assign hb[j] = 1'b0;
    end
    if (LoPos >= 0) begin : g_lo
      assign lb[j] = u_r[j][LoPos];
    end else begin : g_lz
      assign lb[j] = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < SQRT_ITERS; i++) begin
      rs_c[i] = {rem_r[i][61:0], hb[i], lb[i]};
      tr_c[i] = {root_r[i][61:0], 2'b01};
      if (rs_c[i] >= tr_c[i]) begin
        rn_c[i] = rs_c[i] - tr_c[i];
        qn_c[i] = {root_r[i][62:0], 1'b1};
      end else begin
        rn_c[i] = rs_c[i];
        qn_c[i] = {root_r[i][62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r[0]    <= 64'(v);
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      for (int i = 0; i < SQRT_ITERS; i++) begin
        u_r[i+1]    <= u_r[i];
        rem_r[i+1]  <= rn_c[i];
        root_r[i+1] <= qn_c[i];
      end
    end
  end

  assign s = $signed(root_r[SQRT_LAT-1]);

endmodule

// ----- sv/msri_queue.sv -----
`timescale 1ns / 1ps
// small word queue between front and back
module msri_queue import msri_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t wdata,
  input  logic  pop,
  output qent_t rdata,
  output logic  full,
  output logic  empty
);

  qent_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;

  assign full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ----- sv/msri_front.sv -----
`timescale 1ns / 1ps
// front: center at ray time, quadratic terms, discriminant, miss flag
module msri_front import msri_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  ray_t  in_ray,
  input  logic  q_full,
  output logic  q_push,
  output qent_t q_wdata
);

  typedef struct packed {
    logic v;
    ray_t ray;
  } rv_t;

  typedef struct packed {
    logic      v;
    ray_t      ray;
    fx_t [2:0] c;
    fx_t [2:0] oc;
    fx_t       a;
    fx_t       b;
    fx_t       cc;
    fx_t       ta;
    fx_t       tb;
    fx_t       tc;
  } geo_t;

  logic en;
  assign en       = !q_full;
  assign in_ready = en;

  rv_t  s0_r, s0_nxt;
  rv_t  dv_r [DIV_LAT];
  rv_t  mf_r [MUL_LAT];
  geo_t c_r, c_nxt, oc_r, oc_nxt;
  geo_t m9_r [MUL_LAT];
  geo_t x1_r, x1_nxt, x2_r, x2_nxt, x3_r, x3_nxt;
  geo_t m2_r [MUL_LAT];
  fx_t  rr_r, rr_nxt;

  // r*r from config; nonnegative, never saturates
  logic signed [63:0] rprod;
  assign rprod  = cfg.r * cfg.r;
  assign rr_nxt = rprod >>> FRAC_BITS;

  fx_t  num, span, frac;
  logic span_nz;
  fx_t  cdiff [3];
  fx_t  fm    [3];
  fx_t  dd    [3];
  fx_t  ocd   [3];
  fx_t  oo    [3];
  fx_t  bb, acc, disc;

  assign s0_nxt.v   = in_valid;
  assign s0_nxt.ray = in_ray;

  assign num     = ssub(sx32(s0_r.ray.tm), sx32(cfg.s0));
  assign span    = sx32(cfg.s1) - sx32(cfg.s0);
  assign span_nz = (cfg.s1 != cfg.s0);

  msri_div u_frac (.clk(clk), .en(en), .n(num), .d(span), .q(frac));

  genvar i;
  for (i = 0; i < 3; i++) begin : g_ax
    assign cdiff[i] = ssub(sx32(cfg.ce[i]), sx32(cfg.cs[i]));
    msri_mul u_cm (.clk(clk), .en(en), .x(frac), .y(cdiff[i]), .p(fm[i]));
    msri_mul u_dd (.clk(clk), .en(en), .x(sx32(oc_r.ray.d[i])),
                   .y(sx32(oc_r.ray.d[i])), .p(dd[i]));
    msri_mul u_od (.clk(clk), .en(en), .x(oc_r.oc[i]),
                   .y(sx32(oc_r.ray.d[i])), .p(ocd[i]));
    msri_mul u_oo (.clk(clk), .en(en), .x(oc_r.oc[i]), .y(oc_r.oc[i]), .p(oo[i]));
  end

  msri_mul u_bb (.clk(clk), .en(en), .x(x3_r.b), .y(x3_r.b), .p(bb));
  msri_mul u_ac (.clk(clk), .en(en), .x(x3_r.a), .y(x3_r.cc), .p(acc));

  always_comb begin
    c_nxt     = '0;
    c_nxt.v   = mf_r[MUL_LAT-1].v;
    c_nxt.ray = mf_r[MUL_LAT-1].ray;
    for (int k = 0; k < 3; k++) begin
      c_nxt.c[k] = span_nz ? sadd(sx32(cfg.cs[k]), fm[k]) : sx32(cfg.cs[k]);
    end
  end

  always_comb begin
    oc_nxt = c_r;
    for (int k = 0; k < 3; k++) begin
      oc_nxt.oc[k] = ssub(sx32(c_r.ray.o[k]), c_r.c[k]);
    end
  end

  // dot products summed in axis order, saturating at each add
  always_comb begin
    x1_nxt    = m9_r[MUL_LAT-1];
    x1_nxt.a  = sadd(dd[0], dd[1]);
    x1_nxt.b  = sadd(ocd[0], ocd[1]);
    x1_nxt.cc = sadd(oo[0], oo[1]);
    x1_nxt.ta = dd[2];
    x1_nxt.tb = ocd[2];
    x1_nxt.tc = oo[2];
  end

  always_comb begin
    x2_nxt    = x1_r;
    x2_nxt.a  = sadd(x1_r.a, x1_r.ta);
    x2_nxt.b  = sadd(x1_r.b, x1_r.tb);
    x2_nxt.cc = sadd(x1_r.cc, x1_r.tc);
  end

  always_comb begin
    x3_nxt    = x2_r;
    x3_nxt.cc = ssub(x2_r.cc, rr_r);
  end

  assign disc = ssub(bb, acc);

  always_comb begin
    q_wdata      = '0;
    q_wdata.ray  = m2_r[MUL_LAT-1].ray;
    q_wdata.c    = m2_r[MUL_LAT-1].c;
    q_wdata.a    = m2_r[MUL_LAT-1].a;
    q_wdata.b    = m2_r[MUL_LAT-1].b;
    q_wdata.disc = disc;
    q_wdata.miss = (m2_r[MUL_LAT-1].a == '0) || (disc <= 64'sd0);
  end

  assign q_push = en && m2_r[MUL_LAT-1].v;

  always_ff @(posedge clk) begin
    rr_r <= rr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.v <= 1'b0;
      c_r.v  <= 1'b0;
      oc_r.v <= 1'b0;
      x1_r.v <= 1'b0;
      x2_r.v <= 1'b0;
      x3_r.v <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) dv_r[k].v <= 1'b0;
      for (int k = 0; k < MUL_LAT; k++) begin
        mf_r[k].v <= 1'b0;
        m9_r[k].v <= 1'b0;
        m2_r[k].v <= 1'b0;
      end
    end else if (en) begin
      s0_r    <= s0_nxt;
      dv_r[0] <= s0_r;
      for (int k = 1; k < DIV_LAT; k++) dv_r[k] <= dv_r[k-1];
      mf_r[0] <= dv_r[DIV_LAT-1];
      m9_r[0] <= oc_r;
      m2_r[0] <= x3_r;
      for (int k = 1; k < MUL_LAT; k++) begin
        mf_r[k] <= mf_r[k-1];
        m9_r[k] <= m9_r[k-1];
        m2_r[k] <= m2_r[k-1];
      end
      c_r  <= c_nxt;
      oc_r <= oc_nxt;
      x1_r <= x1_nxt;
      x2_r <= x2_nxt;
      x3_r <= x3_nxt;
    end
  end

endmodule

// ----- sv/msri_back.sv -----
`timescale 1ns / 1ps
// back: root, two candidate t, hit point, normal, output register
module msri_back import msri_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  q_empty,
  input  qent_t q_rdata,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  typedef struct packed {
    logic      v;
    qent_t     q;
    fx_t       n1;
    fx_t       n2;
    fx_t       t;
    logic      hit;
    fx_t [2:0] p;
    fx_t [2:0] pc;
  } bk_t;

  logic en;
  logic out_valid_r;
  res_t res_r, res_nxt;

  assign en        = !out_valid_r || out_ready;
  assign q_pop     = en && !q_empty;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  bk_t b0_r, b0_nxt, n_r, n_nxt, t_r, t_nxt, p_r, p_nxt, pc_r, pc_nxt;
  bk_t sq_r [SQRT_LAT];
  bk_t dv_r [DIV_LAT];
  bk_t mt_r [MUL_LAT];
  bk_t dn_r [DIV_LAT];

  fx_t  sroot, negb, t1, t2, rfx;
  fx_t  md [3];
  fx_t  nq [3];
  logic in1, in2;
  bk_t  last;

  assign rfx  = sx32(cfg.r);
  assign last = dn_r[DIV_LAT-1];

  always_comb begin
    b0_nxt   = '0;
    b0_nxt.v = !q_empty;
    b0_nxt.q = q_rdata;
  end

  msri_sqrt u_sqrt (.clk(clk), .en(en), .v(b0_r.q.disc), .s(sroot));

  assign negb = -sq_r[SQRT_LAT-1].q.b;

  always_comb begin
    n_nxt    = sq_r[SQRT_LAT-1];
    n_nxt.n1 = ssub(negb, sroot);
    n_nxt.n2 = sadd(negb, sroot);
  end

  msri_div u_t1 (.clk(clk), .en(en), .n(n_r.n1), .d(n_r.q.a), .q(t1));
  msri_div u_t2 (.clk(clk), .en(en), .n(n_r.n2), .d(n_r.q.a), .q(t2));

  // nearer root first, each strictly inside (t_min, t_max)
  assign in1 = (t1 < sx32(dv_r[DIV_LAT-1].q.ray.thi)) &&
               (t1 > sx32(dv_r[DIV_LAT-1].q.ray.tlo));
  assign in2 = (t2 < sx32(dv_r[DIV_LAT-1].q.ray.thi)) &&
               (t2 > sx32(dv_r[DIV_LAT-1].q.ray.tlo));

  always_comb begin
    t_nxt     = dv_r[DIV_LAT-1];
    t_nxt.t   = in1 ? t1 : t2;
    t_nxt.hit = !dv_r[DIV_LAT-1].q.miss && (in1 || in2);
  end

  genvar i;
  for (i = 0; i < 3; i++) begin : g_ax
    msri_mul u_td (.clk(clk), .en(en), .x(t_r.t), .y(sx32(t_r.q.ray.d[i])), .p(md[i]));
    msri_div u_nr (.clk(clk), .en(en), .n(pc_r.pc[i]), .d(rfx), .q(nq[i]));
  end

  always_comb begin
    p_nxt = mt_r[MUL_LAT-1];
    for (int k = 0; k < 3; k++) begin
      p_nxt.p[k] = sadd(sx32(mt_r[MUL_LAT-1].q.ray.o[k]), md[k]);
    end
  end

  always_comb begin
    pc_nxt = p_r;
    for (int k = 0; k < 3; k++) begin
      pc_nxt.pc[k] = ssub(p_r.p[k], p_r.q.c[k]);
    end
  end

  // a miss reports all-zero fields
  always_comb begin
    res_nxt = '0;
    if (last.hit) begin
      res_nxt.hit = 1'b1;
      res_nxt.t   = outw(last.t);
      for (int k = 0; k < 3; k++) begin
        res_nxt.p[k] = outw(last.p[k]);
        res_nxt.n[k] = (cfg.r == '0) ? '0 : outw(nq[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      b0_r.v      <= 1'b0;
      n_r.v       <= 1'b0;
      t_r.v       <= 1'b0;
      p_r.v       <= 1'b0;
      pc_r.v      <= 1'b0;
      for (int k = 0; k < SQRT_LAT; k++) sq_r[k].v <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) begin
        dv_r[k].v <= 1'b0;
        dn_r[k].v <= 1'b0;
      end
      for (int k = 0; k < MUL_LAT; k++) mt_r[k].v <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.v;
      res_r       <= res_nxt;
      b0_r        <= b0_nxt;
      sq_r[0]     <= b0_r;
      for (int k = 1; k < SQRT_LAT; k++) sq_r[k] <= sq_r[k-1];
      n_r     <= n_nxt;
      dv_r[0] <= n_r;
      dn_r[0] <= pc_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        dv_r[k] <= dv_r[k-1];
        dn_r[k] <= dn_r[k-1];
      end
      t_r     <= t_nxt;
      mt_r[0] <= t_r;
      for (int k = 1; k < MUL_LAT; k++) mt_r[k] <= mt_r[k-1];
      p_r  <= p_nxt;
      pc_r <= pc_nxt;
    end
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import msri_pkg::*;

  // register map: one 64-bit slot per register, byte address 8*index
  typedef enum int {
    R_CS_X = 0, R_CS_Y = 1, R_CS_Z = 2,
    R_CE_X = 3, R_CE_Y = 4, R_CE_Z = 5,
    R_SHUTTER = 6, R_RADIUS = 7
  } reg_idx_e;

  localparam w32_t ONE = 32'sh0001_0000;   // 1.0 in Q16.16
  localparam w32_t MAXV = 32'sh7FFF_FFFF;
  localparam w32_t MINV = 32'sh8000_0000;

  logic              clk;
  logic              rst_n;
  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [63:0]       pwdata, prdata;
  logic              in_valid, in_ready;
  logic [31:0]       in_origin_x, in_origin_y, in_origin_z;
  logic [31:0]       in_dir_x, in_dir_y, in_dir_z;
  logic [31:0]       in_ray_time, in_t_min, in_t_max;
  logic              out_valid, out_ready, out_hit;
  logic [31:0]       out_hit_t, out_point_x, out_point_y, out_point_z;
  logic [31:0]       out_normal_x, out_normal_y, out_normal_z;

  moving_sphere_ray_intersect_core dut (.*);

  // sphere setup as last written, kept for hit prediction
  fx_t  ctr_open[3], ctr_close[3], rad_fx;
  w32_t shut_open, shut_close;

  res_t hit_q[$];        // expected words, oldest first
  int   n_err = 0;
  int   n_rays = 0;
  int   n_words = 0;
  int   n_hits = 0;
  int   n_settings = 0;
  bit   hold_req = 0;    // ask receiver for one long stall
  bit   calm = 0;        // no idling on either side

  // ---------------------------------------------------------------
  // saturating fixed-point helpers, +-(2^62-1) internal range
  // ---------------------------------------------------------------
  function automatic fx_t clip62(logic signed [64:0] v);
    if (v > 65'sh0_3FFF_FFFF_FFFF_FFFF) return LIM;
    if (v < -65'sh0_3FFF_FFFF_FFFF_FFFF) return -LIM;
    return v[63:0];
  endfunction

  function automatic fx_t fadd(fx_t x, fx_t y);
    logic signed [64:0] s;
    s = x;
    s = s + y;
    return clip62(s);
  endfunction

  function automatic fx_t fsub(fx_t x, fx_t y);
    logic signed [64:0] s;
    s = x;
    s = s - y;
    return clip62(s);
  endfunction

  function automatic logic [63:0] absv(fx_t v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // product shifted down by the fraction width, truncated toward zero
  function automatic fx_t fmul(fx_t x, fx_t y);
    logic [127:0] pr;
    fx_t q;
    pr = (128'(absv(x)) * 128'(absv(y))) >> FRAC_BITS;
    q = (pr > 128'(LIM)) ? LIM : fx_t'(pr[63:0]);
    return ((x < 0) != (y < 0)) ? -q : q;
  endfunction

  function automatic fx_t fdiv(fx_t n, fx_t d);
    logic [127:0] qq;
    fx_t q;
    if (d == 0) return 0;
    qq = (128'(absv(n)) << FRAC_BITS) / 128'(absv(d));
    q = (qq > 128'(LIM)) ? LIM : fx_t'(qq[63:0]);
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  // floor(sqrt(v * 2^FRAC_BITS)), v positive
  function automatic fx_t fsqrt(fx_t v);
    logic [127:0] x, root, cand;
    x = 128'(v) << FRAC_BITS;
    root = 0;
    for (int i = 39; i >= 0; i--) begin
      cand = root | (128'd1 << i);
      if (cand * cand <= x) root = cand;
    end
    return fx_t'(root[63:0]);
  endfunction

  function automatic w32_t sat32(fx_t v);
    if (v > 64'sd2147483647) return MAXV;
    if (v < -64'sd2147483648) return MINV;
    return v[31:0];
  endfunction

  // expected word for one ray against the current sphere setup
  function automatic res_t predict_hit(ray_t r);
    fx_t o[3], d[3], c[3], oc[3], p[3];
    fx_t tm, tlo, thi, span, frac, a, b, cc, disc, s, t;
    res_t e;
    e = '0;
    tm = fx_t'(r.tm);
    tlo = fx_t'(r.tlo);
    thi = fx_t'(r.thi);
    span = fx_t'(shut_close) - fx_t'(shut_open);
    frac = 0;
    if (span != 0) frac = fdiv(fsub(tm, fx_t'(shut_open)), span);
    a = 0;
    b = 0;
    cc = 0;
    for (int i = 0; i < 3; i++) begin
      o[i] = fx_t'(r.o[i]);
      d[i] = fx_t'(r.d[i]);
      c[i] = (span == 0) ? ctr_open[i]
           : fadd(ctr_open[i], fmul(frac, fsub(ctr_close[i], ctr_open[i])));
      oc[i] = fsub(o[i], c[i]);
      a = fadd(a, fmul(d[i], d[i]));
      b = fadd(b, fmul(oc[i], d[i]));
      cc = fadd(cc, fmul(oc[i], oc[i]));
    end
    cc = fsub(cc, fmul(rad_fx, rad_fx));
    if (a == 0) return e;                 // degenerate direction
    disc = fsub(fmul(b, b), fmul(a, cc));
    if (disc <= 0) return e;              // no crossing, or grazing
    s = fsqrt(disc);
    t = fdiv(fsub(-b, s), a);             // near root first
    if (!(t < thi && t > tlo)) begin
      t = fdiv(fadd(-b, s), a);
      if (!(t < thi && t > tlo)) return e;
    end
    e.hit = 1'b1;
    e.t = sat32(t);
    for (int i = 0; i < 3; i++) begin
      p[i] = fadd(o[i], fmul(t, d[i]));
      e.p[i] = sat32(p[i]);
      e.n[i] = (rad_fx == 0) ? 32'sd0 : sat32(fdiv(fsub(p[i], c[i]), rad_fx));
    end
    return e;
  endfunction

  // ---------------------------------------------------------------
  // random field values
  // ---------------------------------------------------------------
  function automatic w32_t srnd(int m);
    return w32_t'(int'($urandom_range(0, 2 * m)) - m);
  endfunction

  function automatic w32_t any_fx();
    case ($urandom_range(0, 3))
      0: return w32_t'($urandom);
      1: return srnd(20 << 16);
      2: case ($urandom_range(0, 4))
           0: return MAXV;
           1: return MINV;
           2: return 32'sd0;
           3: return 32'sd1;
           default: return -32'sd1;
         endcase
      default: return srnd(255);
    endcase
  endfunction

  // aimed rays start near the sphere and point at a spot close to it
  function automatic ray_t make_ray(bit aimed);
    ray_t r;
    w32_t tgt;
    for (int i = 0; i < 3; i++) begin
      if (aimed) begin
        r.o[i] = w32_t'(ctr_open[i]) + srnd(30 << 16);
        tgt = w32_t'(ctr_open[i]) + srnd(3 << 16);
        r.d[i] = tgt - r.o[i];
        if ($urandom_range(0, 3) == 0) r.d[i] = r.d[i] >>> $urandom_range(0, 6);
      end else begin
        r.o[i] = any_fx();
        r.d[i] = any_fx();
      end
    end
    if (aimed) begin
      r.tm = shut_open + srnd(2 << 16);
      r.tlo = srnd(1 << 16);
      r.thi = w32_t'($urandom_range(0, 1 << 22));
    end else begin
      r.tm = any_fx();
      r.tlo = any_fx();
      r.thi = any_fx();
    end
    return r;
  endfunction

  function automatic ray_t mkray(w32_t ox, w32_t oy, w32_t oz, w32_t dx, w32_t dy,
                                 w32_t dz, w32_t tm, w32_t tlo, w32_t thi);
    ray_t r;
    r.o[0] = ox; r.o[1] = oy; r.o[2] = oz;
    r.d[0] = dx; r.d[1] = dy; r.d[2] = dz;
    r.tm = tm; r.tlo = tlo; r.thi = thi;
    return r;
  endfunction

  // ---------------------------------------------------------------
  // clock, reset and the timeout
  // ---------------------------------------------------------------
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------
  // config port: setup cycle, then access cycle
  // ---------------------------------------------------------------
  task automatic reg_write(reg_idx_e idx, logic [63:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(int'(idx) * 8);
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);           // register takes the value at this edge
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      R_CS_X, R_CS_Y, R_CS_Z: ctr_open[int'(idx)] = fx_t'(w32_t'(v[31:0]));
      R_CE_X, R_CE_Y, R_CE_Z: ctr_close[int'(idx) - 3] = fx_t'(w32_t'(v[31:0]));
      R_SHUTTER: begin
        shut_open = v[31:0];
        shut_close = v[63:32];
      end
      default: rad_fx = fx_t'(w32_t'(v[31:0]));
    endcase
  endtask

  task automatic load_sphere(w32_t cs[3], w32_t ce[3], w32_t s0, w32_t s1, w32_t r);
    reg_write(R_CS_X, 64'(cs[0]));
    reg_write(R_CS_Y, 64'(cs[1]));
    reg_write(R_CS_Z, 64'(cs[2]));
    reg_write(R_CE_X, 64'(ce[0]));
    reg_write(R_CE_Y, 64'(ce[1]));
    reg_write(R_CE_Z, 64'(ce[2]));
    reg_write(R_SHUTTER, {s1, s0});
    reg_write(R_RADIUS, 64'(r));
    n_settings++;
  endtask

  // sphere setups used by the phases; 0 is the one the directed rows assume
  task automatic setup_phase(int ph);
    w32_t cs[3], ce[3];
    w32_t s0, s1, r;
    for (int i = 0; i < 3; i++) begin
      cs[i] = srnd(20 << 16);
      ce[i] = srnd(20 << 16);
    end
    s0 = 0;
    s1 = ONE;
    r = w32_t'($urandom_range(1 << 15, 8 << 16));
    case (ph)
      0: begin
        cs = '{0, 0, 10 * ONE};
        ce = '{4 * ONE, 0, 10 * ONE};
        r = 2 * ONE;
      end
      2: begin               // still sphere, flipped normals
        s0 = srnd(4 << 16);
        s1 = s0;
        r = -r;
      end
      3: begin
        cs = '{MAXV, MAXV, MAXV};
        ce = '{MAXV, MAXV, MAXV};
        s0 = MAXV;
        s1 = MINV;
        r = MAXV;
      end
      4: begin
        cs = '{MINV, MINV, MINV};
        ce = '{MINV, MINV, MINV};
        s0 = MINV;
        s1 = MAXV;
        r = MINV;
      end
      5: begin
        for (int i = 0; i < 3; i++) begin
          cs[i] = $urandom;
          ce[i] = $urandom;
        end
        s0 = $urandom;
        s1 = $urandom;
        r = $urandom;
      end
      6: r = 0;              // normals forced to zero
      default: ;
    endcase
    load_sphere(cs, ce, s0, s1, r);
  endtask

  // ---------------------------------------------------------------
  // ray sender: called at a rising edge, returns at the accepting edge
  // ---------------------------------------------------------------
  task automatic send_ray(ray_t r, bit typed, res_t typed_res);
    in_valid <= 1'b1;
    in_origin_x <= r.o[0];
    in_origin_y <= r.o[1];
    in_origin_z <= r.o[2];
    in_dir_x <= r.d[0];
    in_dir_y <= r.d[1];
    in_dir_z <= r.d[2];
    in_ray_time <= r.tm;
    in_t_min <= r.tlo;
    in_t_max <= r.thi;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    hit_q.push_back(typed ? typed_res : predict_hit(r));
    n_rays++;
    @(posedge clk);
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // idle both channels, then reload the sphere
  task automatic drain_and_setup(int ph);
    in_valid <= 1'b0;
    wait (hit_q.size() == 0);
    repeat (4) @(posedge clk);
    setup_phase(ph);
    @(posedge clk);
  endtask

  // directed rows; step 0 runs on the reset setup, step 1 on phase 0
  typedef struct {
    int   step;
    ray_t ray;
    bit   typed;
  } row_t;

  row_t rows[$];

  task automatic add_row(int step, ray_t r, bit typed);
    row_t w;
    w.step = step;
    w.ray = r;
    w.typed = typed;
    rows.push_back(w);
  endtask

  initial begin
    int step;
    int n_per;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0;
    {in_origin_x, in_origin_y, in_origin_z} = '0;
    {in_dir_x, in_dir_y, in_dir_z} = '0;
    {in_ray_time, in_t_min, in_t_max} = '0;
    for (int i = 0; i < 3; i++) begin
      ctr_open[i] = 0;
      ctr_close[i] = 0;
    end
    rad_fx = 0;
    shut_open = 0;
    shut_close = 0;
    rst_n = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setup: zero-radius sphere at the origin, zero shutter span
    add_row(0, mkray(0, 0, 0, 0, 0, 0, 0, MINV, MAXV), 1);          // no direction
    add_row(0, mkray(0, 0, -5 * ONE, 0, 0, ONE, 0, 0, 100 * ONE), 1); // grazing, disc 0
    add_row(0, mkray(0, 0, 0, 1, 1, 1, 0, MINV, MAXV), 1);          // a truncates to 0
    add_row(0, mkray(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV), 0);
    add_row(0, mkray(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV), 0);
    // moving sphere: z = 10, x slides 0 -> 4 over shutter 0..1, radius 2
    add_row(1, mkray(0, 0, 0, 0, 0, ONE, 0, 0, 100 * ONE), 0);
    add_row(1, mkray(0, 0, 0, 0, 0, ONE, ONE / 2, 0, 100 * ONE), 0);
    add_row(1, mkray(0, 0, 0, 0, 0, ONE, ONE, 0, 100 * ONE), 0);
    add_row(1, mkray(0, 0, 0, 0, 0, ONE, 3 * ONE, 0, 100 * ONE), 0);   // past close
    add_row(1, mkray(0, 0, 0, 0, 0, ONE, -2 * ONE, 0, 100 * ONE), 0);  // before open
    add_row(1, mkray(0, 0, 10 * ONE, 0, 0, ONE, 0, 0, 100 * ONE), 0);  // from inside
    add_row(1, mkray(0, 0, 0, 0, 0, ONE, 0, 20 * ONE, 30 * ONE), 0);   // both roots out
    add_row(1, mkray(0, 0, 0, 0, 0, ONE, 0, 100 * ONE, 0), 0);         // empty interval
    add_row(1, mkray(0, 0, 0, 0, 0, ONE, 0, 8 * ONE, 100 * ONE), 0);   // near root on bound
    add_row(1, mkray(0, 0, 20 * ONE, 0, 0, -ONE, 0, 0, 100 * ONE), 0);
    add_row(1, mkray(0, 0, 0, 0, 0, 32'sh7FFF_0000, 0, MINV, MAXV), 0);
    add_row(1, mkray(MAXV, 0, 0, MINV, 0, 10 * ONE, 0, MINV, MAXV), 0);
    add_row(1, mkray(10 * ONE, 0, 0, 0, 0, ONE, 0, 0, 100 * ONE), 0);  // passes beside
    add_row(1, mkray(2 * ONE, 0, 0, 0, 0, ONE, 0, 0, 100 * ONE), 0);   // touches edge
    add_row(1, mkray(0, 0, 0, ONE, ONE, ONE, 0, MINV, MAXV), 0);

    step = 0;
    foreach (rows[k]) begin
      if (rows[k].step != step) begin
        drain_and_setup(0);
        step = rows[k].step;
      end
      send_ray(rows[k].ray, rows[k].typed, '0);
      sender_gap();
    end

    // random part: one sphere setup per phase, mostly aimed rays
    n_per = 330;
    for (int ph = 1; ph <= 6; ph++) begin
      drain_and_setup(ph);
      if (ph == 1) hold_req = 1;     // receiver stalls while we keep pushing
      if (ph == 6) calm = 1;
      for (int k = 0; k < n_per; k++) begin
        if (ph == 2 && k == n_per / 2) begin
          in_valid <= 1'b0;
          wait (hit_q.size() == 0);  // let the pipe run dry mid-phase
          @(posedge clk);
        end
        send_ray(make_ray($urandom_range(0, 9) < 7), 0, '0);
        sender_gap();
      end
    end
    in_valid <= 1'b0;

    wait (hit_q.size() == 0);
    repeat (400) @(posedge clk);
    $display("%0d rays over %0d sphere setups, %0d words checked, %0d hits",
             n_rays, n_settings, n_words, n_hits);
    if (n_err == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------
  // receiver: random stall bursts, one long hold-off on request
  // ---------------------------------------------------------------
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------
  // checker: a word moves at the next rising edge, sample mid-cycle
  // ---------------------------------------------------------------
  task automatic cmp_field(string nm, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %h, got %h", nm, e, a);
      n_err++;
    end
  endtask

  always @(negedge clk) begin
    res_t e;
    if (rst_n && out_valid && out_ready) begin
      n_words++;
      if (hit_q.size() == 0) begin
        $error("result word with nothing expected");
        n_err++;
      end else begin
        e = hit_q.pop_front();
        if (e.hit) n_hits++;
        cmp_field("hit", 32'(e.hit), 32'(out_hit));
        cmp_field("hit_t", e.t, out_hit_t);
        cmp_field("point_x", e.p[0], out_point_x);
        cmp_field("point_y", e.p[1], out_point_y);
        cmp_field("point_z", e.p[2], out_point_z);
        cmp_field("normal_x", e.n[0], out_normal_x);
        cmp_field("normal_y", e.n[1], out_normal_y);
        cmp_field("normal_z", e.n[2], out_normal_z);
      end
    end
  end

endmodule

// ----- sim.f -----
sv/msri_pkg.sv
sv/msri_mul.sv
sv/msri_div.sv
sv/msri_sqrt.sv
sv/msri_queue.sv
sv/msri_front.sv
sv/msri_back.sv
sv/moving_sphere_ray_intersect_core.sv
verif/tb_top.sv
